@@ design/plcc_pkg.sv @@
// Shared types, codes and widths for the pinned LRU page cache core.
// No dependencies; every other design file imports this package.
`default_nettype none
package plcc_pkg;

  localparam int PAGE_W      = 31;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int FRAME_IDX_W = 6;
  localparam int GROUP_SIZE  = 8;

  localparam int DEF_FRAMES  = 16;
  localparam int DEF_PIN_MAX = 255;

  // Request codes
  localparam logic [OP_W-1:0] OP_FETCH = 2'd0;
  localparam logic [OP_W-1:0] OP_UNPIN = 2'd1;
  localparam logic [OP_W-1:0] OP_NEW   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNPIN_MISS = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;   // capture the request beat
    logic look;    // compare lanes, reduce groups
    logic decide;  // final victim and hit encode
    logic commit;  // update frames, load result register
  } ctl_cmd_t;

endpackage
`default_nettype wire

@@ design/pinned_lru_page_cache_core.sv @@
// Top level of the pinned LRU page cache: buffer pool frame metadata.
// Depends on plcc_pkg, plcc_ctrl and plcc_dpath.
//
//   channel  handshake             beat contents
//   -------  --------------------  ------------------------------------------------
//   in       in_valid / in_ready   operation, page_id, mark_dirty, fresh_page_id
//   out      out_valid / out_ready status, frame_index, was_hit, need_read,
//                                  need_zero, need_writeback, writeback_page,
//                                  granted_page
//
// Each request passes through accept, lane compare plus per-group victim minimum
// (groups of eight frames), final minimum and hit encode, then commit. The
// victim search tree has two registered levels.
// Commit waits while the result register still holds an untaken beat; a new
// request is accepted while that beat waits.
// Reset (rst, synchronous) empties all frames and ranks them by index, frame 0
// oldest; in_ready is high in the first cycle after reset.
`default_nettype none
module pinned_lru_page_cache_core #(
  parameter int FRAMES  = plcc_pkg::DEF_FRAMES,
  parameter int PIN_MAX = plcc_pkg::DEF_PIN_MAX
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [plcc_pkg::OP_W-1:0]          operation,
  input  wire logic [plcc_pkg::PAGE_W-1:0]        page_id,
  input  wire logic                               mark_dirty,
  input  wire logic [plcc_pkg::PAGE_W-1:0]        fresh_page_id,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [plcc_pkg::STATUS_W-1:0]      status,
  output logic      [plcc_pkg::FRAME_IDX_W-1:0]   frame_index,
  output logic                                    was_hit,
  output logic                                    need_read,
  output logic                                    need_zero,
  output logic                                    need_writeback,
  output logic      [plcc_pkg::PAGE_W-1:0]        writeback_page,
  output logic      [plcc_pkg::PAGE_W-1:0]        granted_page
);
  import plcc_pkg::*;

  ctl_cmd_t cmd;

  // Sequence one request beat at a time through the search stages.
  plcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Hold frame state, search for hit and victim, form the result beat.
  plcc_dpath #(
    .FRAMES  (FRAMES),
    .PIN_MAX (PIN_MAX)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .operation      (operation),
    .page_id        (page_id),
    .mark_dirty     (mark_dirty),
    .fresh_page_id  (fresh_page_id),
    .status         (status),
    .frame_index    (frame_index),
    .was_hit        (was_hit),
    .need_read      (need_read),
    .need_zero      (need_zero),
    .need_writeback (need_writeback),
    .writeback_page (writeback_page),
    .granted_page   (granted_page)
  );

  // Only one request is in flight: acceptance closes the input side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted while one is in flight");

  // A fresh result beat appears only at the end of request work.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without a request in flight");

  // A full pool reports nothing but its status.
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |->
      (frame_index == '0 && !was_hit && !need_read && !need_zero &&
       !need_writeback && granted_page == '0))
    else $error("pool-full result carries nonzero fields");

  // A fetch hit never asks for disk or zeroing work.
  a_hit_no_io: assert property (@(posedge clk) disable iff (rst)
    (out_valid && was_hit) |-> (!need_read && !need_zero && !need_writeback))
    else $error("hit result requests frame load or writeback");

endmodule
`default_nettype wire

@@ design/plcc_ctrl.sv @@
// Sequencer for the pinned LRU page cache: one request at a time.
// Depends on plcc_pkg for the command struct.
`default_nettype none
module plcc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output plcc_pkg::ctl_cmd_t      cmd
);
  import plcc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOK   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   commit_go;

  assign in_ready  = (state == S_IDLE);
  assign commit_go = (state == S_COMMIT) && (!out_valid || out_ready);

  always_comb begin
    cmd.latch  = in_valid && in_ready;
    cmd.look   = (state == S_LOOK);
    cmd.decide = (state == S_DECIDE);
    cmd.commit = commit_go;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_LOOK;
      S_LOOK:   state_next = S_DECIDE;
      S_DECIDE: state_next = S_COMMIT;
      S_COMMIT: if (commit_go) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Hold the result until taken; a new result may replace one taken this cycle.
  always_comb begin
    if (commit_go) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

@@ design/plcc_dpath.sv @@
// Frame metadata lanes, victim search tree, commit logic and result register.
// Depends on plcc_pkg; sequenced by plcc_ctrl through ctl_cmd_t.
`default_nettype none
module plcc_dpath #(
  parameter int FRAMES  = plcc_pkg::DEF_FRAMES,
  parameter int PIN_MAX = plcc_pkg::DEF_PIN_MAX
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire plcc_pkg::ctl_cmd_t                 cmd,
  input  wire logic [plcc_pkg::OP_W-1:0]          operation,
  input  wire logic [plcc_pkg::PAGE_W-1:0]        page_id,
  input  wire logic                               mark_dirty,
  input  wire logic [plcc_pkg::PAGE_W-1:0]        fresh_page_id,
  output logic      [plcc_pkg::STATUS_W-1:0]      status,
  output logic      [plcc_pkg::FRAME_IDX_W-1:0]   frame_index,
  output logic                                    was_hit,
  output logic                                    need_read,
  output logic                                    need_zero,
  output logic                                    need_writeback,
  output logic      [plcc_pkg::PAGE_W-1:0]        writeback_page,
  output logic      [plcc_pkg::PAGE_W-1:0]        granted_page
);
  import plcc_pkg::*;

  localparam int RANK_W = $clog2(FRAMES);
  localparam int IDX_W  = RANK_W;
  localparam int PIN_W  = $clog2(PIN_MAX + 1);
  localparam int KEY_W  = RANK_W + 1;
  localparam int NGROUP = (FRAMES + GROUP_SIZE - 1) / GROUP_SIZE;

  // Frame lanes
  logic [PAGE_W-1:0] frame_page     [FRAMES];
  logic [FRAMES-1:0] frame_valid;
  logic [PIN_W-1:0]  frame_pins     [FRAMES];
  logic [FRAMES-1:0] frame_modified;
  logic [RANK_W-1:0] recency_rank   [FRAMES];

  // Request
  logic [OP_W-1:0]   req_op;
  logic [PAGE_W-1:0] req_key;
  logic              req_dirty;

  // Search pipeline
  logic [KEY_W-1:0]  lane_key     [FRAMES];
  logic [KEY_W-1:0]  grp_key_c    [NGROUP];
  logic [IDX_W-1:0]  grp_idx_c    [NGROUP];
  logic [KEY_W-1:0]  grp_key      [NGROUP];
  logic [IDX_W-1:0]  grp_idx      [NGROUP];
  logic [FRAMES-1:0] hit_vec;
  logic [KEY_W-1:0]  fin_key_c;
  logic [IDX_W-1:0]  fin_idx_c;
  logic [IDX_W-1:0]  hit_idx_c;
  logic              hit_any, vict_any;
  logic [IDX_W-1:0]  hit_idx, vict_idx;

  // Commit decisions
  logic              do_touch, do_install, do_pin_inc, do_unpin, do_kill;
  logic [IDX_W-1:0]  touch_idx;
  logic [RANK_W-1:0] touch_old;
  logic              vict_wb;
  logic [STATUS_W-1:0]    res_status;
  logic [FRAME_IDX_W-1:0] res_frame;
  logic              res_hit, res_read, res_zero, res_wb;
  logic [PAGE_W-1:0] res_wb_page, res_granted;

  // Victim key: pinned frames sort after every unpinned one.
  always_comb begin
    for (int f = 0; f < FRAMES; f++) begin
      lane_key[f] = {(frame_pins[f] != '0), recency_rank[f]};
    end
  end

  always_comb begin
    for (int j = 0; j < NGROUP; j++) begin
      grp_key_c[j] = '1;
      grp_idx_c[j] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (j * GROUP_SIZE + k < FRAMES) begin
          if (lane_key[j * GROUP_SIZE + k] < grp_key_c[j]) begin
            grp_key_c[j] = lane_key[j * GROUP_SIZE + k];
            grp_idx_c[j] = IDX_W'(j * GROUP_SIZE + k);
          end
        end
      end
    end
  end

  always_comb begin
    fin_key_c = '1;
    fin_idx_c = '0;
    for (int j = 0; j < NGROUP; j++) begin
      if (grp_key[j] < fin_key_c) begin
        fin_key_c = grp_key[j];
        fin_idx_c = grp_idx[j];
      end
    end
  end

  // Lowest matching frame wins.
  always_comb begin
    hit_idx_c = '0;
    for (int f = FRAMES - 1; f >= 0; f--) begin
      if (hit_vec[f]) hit_idx_c = IDX_W'(f);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_op    <= operation;
      req_key   <= (operation == OP_NEW) ? fresh_page_id : page_id;
      req_dirty <= mark_dirty;
    end
    if (cmd.look) begin
      for (int f = 0; f < FRAMES; f++) begin
        hit_vec[f] <= frame_valid[f] && (frame_page[f] == req_key);
      end
      for (int j = 0; j < NGROUP; j++) begin
        grp_key[j] <= grp_key_c[j];
        grp_idx[j] <= grp_idx_c[j];
      end
    end
    if (cmd.decide) begin
      hit_any  <= |hit_vec;
      hit_idx  <= hit_idx_c;
      vict_any <= !fin_key_c[KEY_W-1];
      vict_idx <= fin_idx_c;
    end
  end

  assign vict_wb   = frame_valid[vict_idx] && frame_modified[vict_idx];
  assign touch_old = recency_rank[touch_idx];

  always_comb begin
    do_touch    = 1'b0;
    do_install  = 1'b0;
    do_pin_inc  = 1'b0;
    do_unpin    = 1'b0;
    do_kill     = 1'b0;
    touch_idx   = hit_idx;
    res_status  = ST_DONE;
    res_frame   = '0;
    res_hit     = 1'b0;
    res_read    = 1'b0;
    res_zero    = 1'b0;
    res_wb      = 1'b0;
    res_wb_page = '0;
    res_granted = '0;
    unique case (req_op)
      OP_FETCH: begin
        if (hit_any) begin
          do_pin_inc  = 1'b1;
          do_touch    = 1'b1;
          res_frame   = FRAME_IDX_W'(hit_idx);
          res_hit     = 1'b1;
          res_granted = req_key;
        end else if (!vict_any) begin
          res_status = ST_FULL;
        end else begin
          do_install  = 1'b1;
          do_touch    = 1'b1;
          touch_idx   = vict_idx;
          res_frame   = FRAME_IDX_W'(vict_idx);
          res_read    = 1'b1;
          res_wb      = vict_wb;
          res_wb_page = vict_wb ? frame_page[vict_idx] : '0;
          res_granted = req_key;
        end
      end
      OP_UNPIN: begin
        if (hit_any) begin
          do_unpin  = 1'b1;
          res_frame = FRAME_IDX_W'(hit_idx);
        end else begin
          res_status = ST_UNPIN_MISS;
        end
      end
      OP_NEW: begin
        if (!vict_any) begin
          res_status = ST_FULL;
        end else begin
          do_kill     = hit_any && (hit_idx != vict_idx);
          do_install  = 1'b1;
          do_touch    = 1'b1;
          touch_idx   = vict_idx;
          res_frame   = FRAME_IDX_W'(vict_idx);
          res_zero    = 1'b1;
          res_wb      = vict_wb;
          res_wb_page = vict_wb ? frame_page[vict_idx] : '0;
          res_granted = req_key;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid    <= '0;
      frame_modified <= '0;
      for (int f = 0; f < FRAMES; f++) begin
        frame_page[f]   <= '0;
        frame_pins[f]   <= '0;
        recency_rank[f] <= RANK_W'(f);
      end
    end else if (cmd.commit) begin
      if (do_touch) begin
        for (int f = 0; f < FRAMES; f++) begin
          if (recency_rank[f] > touch_old) recency_rank[f] <= recency_rank[f] - 1'b1;
        end
        recency_rank[touch_idx] <= RANK_W'(FRAMES - 1);
      end
      if (do_pin_inc && frame_pins[hit_idx] < PIN_W'(PIN_MAX)) begin
        frame_pins[hit_idx] <= frame_pins[hit_idx] + 1'b1;
      end
      if (do_unpin) begin
        if (req_dirty) frame_modified[hit_idx] <= 1'b1;
        if (frame_pins[hit_idx] != '0) frame_pins[hit_idx] <= frame_pins[hit_idx] - 1'b1;
      end
      // Drop a stale copy of the fresh id held in some frame other than the victim.
      if (do_kill) frame_valid[hit_idx] <= 1'b0;
      if (do_install) begin
        frame_page[vict_idx]     <= req_key;
        frame_valid[vict_idx]    <= 1'b1;
        frame_pins[vict_idx]     <= PIN_W'(1);
        frame_modified[vict_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status         <= res_status;
      frame_index    <= res_frame;
      was_hit        <= res_hit;
      need_read      <= res_read;
      need_zero      <= res_zero;
      need_writeback <= res_wb;
      writeback_page <= res_wb_page;
      granted_page   <= res_granted;
    end
  end

endmodule
`default_nettype wire
